FILE: hdl/bobl_pkg.sv
// Package: shared widths, request/status/operation codes and the cell control bundle.
package bobl_pkg;

  localparam int KEY_W     = 8;
  localparam int REQ_W     = 3;
  localparam int STAT_W    = 3;
  localparam int POS_W     = 4;
  localparam int CNT_OUT_W = 5;
  localparam int LIMIT_W   = 5;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd10;

  // request types
  localparam logic [REQ_W-1:0] REQ_INS_FRONT = 3'd0;
  localparam logic [REQ_W-1:0] REQ_INS_AFTER = 3'd1;
  localparam logic [REQ_W-1:0] REQ_DEL_AFTER = 3'd2;
  localparam logic [REQ_W-1:0] REQ_DEL_LAST  = 3'd3;
  localparam logic [REQ_W-1:0] REQ_SEARCH    = 3'd4;

  // result status
  localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 3'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 3'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STAT_W-1:0] ST_NO_NEXT   = 3'd4;

  typedef logic [1:0] cell_op_t;

  // cell update operations
  localparam cell_op_t OP_HOLD      = 2'd0;
  localparam cell_op_t OP_INSERT    = 2'd1;
  localparam cell_op_t OP_DEL_AFTER = 2'd2;
  localparam cell_op_t OP_DEL_LAST  = 2'd3;

  typedef struct packed {
    logic             load;   // capture the key compare
    logic [KEY_W-1:0] key;
    cell_op_t         op;
    logic [KEY_W-1:0] value;
  } cell_ctl_t;

endpackage

FILE: hdl/bobl_ifs.sv
// Interfaces: request channel and result channel, valid/ready handshake.
interface bobl_req_if;
  logic       valid;
  logic       ready;
  logic [2:0] req_type;
  logic [7:0] key;
  logic [7:0] value;

  modport source (output valid, output req_type, output key, output value, input ready);
  modport sink   (input valid, input req_type, input key, input value, output ready);
endinterface

interface bobl_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [3:0] match_pos;
  logic [4:0] entry_count;

  modport source (output valid, output status, output match_pos, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input match_pos, input entry_count,
                  output ready);
endinterface

FILE: hdl/bobl_cell.sv
// List cell: one byte entry, its occupied flag and its slice of the first-match chain.
module bobl_cell (
  input  logic                        clk,
  input  logic                        rst_n,
  input  bobl_pkg::cell_ctl_t         ctl,
  input  logic [bobl_pkg::KEY_W-1:0]  left_data,
  input  logic                        left_occ,
  input  logic                        left_seen,
  input  logic                        left_first,
  input  logic [bobl_pkg::KEY_W-1:0]  right_data,
  input  logic                        right_occ,
  output logic [bobl_pkg::KEY_W-1:0]  data,
  output logic                        occ,
  output logic                        seen_out,
  output logic                        first_out
);
  import bobl_pkg::*;

  logic [KEY_W-1:0] data_r, data_nxt;
  logic             occ_r, occ_nxt;
  logic             match_r, match_nxt;

  // a match anywhere up to and including this cell
  assign seen_out  = left_seen | match_r;
  assign first_out = match_r & ~left_seen;
  assign data      = data_r;
  assign occ       = occ_r;

  always_comb begin
    data_nxt  = data_r;
    occ_nxt   = occ_r;
    match_nxt = match_r;
    if (ctl.load) begin
      match_nxt = occ_r && (data_r == ctl.key);
    end
    case (ctl.op)
      OP_INSERT: begin
        // shift right past the insertion point
        if (left_seen) begin
          data_nxt = left_first ? ctl.value : left_data;
          occ_nxt  = left_occ;
        end
      end
      OP_DEL_AFTER: begin
        // pull from the right past the match
        if (left_seen) begin
          data_nxt = right_data;
          occ_nxt  = right_occ;
        end
      end
      OP_DEL_LAST: begin
        occ_nxt = occ_r & right_occ;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r   <= 1'b0;
      match_r <= 1'b0;
    end else begin
      occ_r   <= occ_nxt;
      match_r <= match_nxt;
    end
  end

endmodule

FILE: hdl/bounded_ordered_byte_list_top.sv
// Top level: bounded ordered byte list built as a chain of list cells.
// Each request runs as a compare step, when the request is accepted, then an update step
//   that registers the result; the update waits while an earlier result is still held
//   on the result channel. No new request is taken until the update is done.
// Reset (rst_n low, synchronous): list empty, count 0, limit back to 10, no result
//   pending. Entry bytes are not cleared; the occupied flags gate every compare.
module bounded_ordered_byte_list_top #(
  parameter int CAPACITY = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  bobl_req_if.sink                      in_req,
  bobl_rsp_if.source                    out_rsp,
  input  logic                          cfg_we,
  input  logic [bobl_pkg::LIMIT_W-1:0]  cfg_wdata
);
  import bobl_pkg::*;

  localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int PW = CW + 1;
  localparam int LW = (CW > LIMIT_W) ? CW : LIMIT_W;

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_r, state_nxt;

  // held request
  logic [REQ_W-1:0] req_r;
  logic [KEY_W-1:0] value_r;

  logic [LIMIT_W-1:0] limit_r;
  logic [CW-1:0]      count_r, count_nxt;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  logic [STAT_W-1:0]    status_r, status_nxt;
  logic [POS_W-1:0]     pos_out_r, pos_out_nxt;
  logic [CNT_OUT_W-1:0] cnt_out_r, cnt_out_nxt;

  cell_ctl_t ctl;
  cell_op_t  op;

  logic [KEY_W-1:0] data_w  [CAPACITY];
  logic             occ_w   [CAPACITY];
  logic             seen_w  [CAPACITY];
  logic             first_w [CAPACITY];

  logic           accept, commit, front_ins, found, full;
  logic [IW-1:0]  pos;
  logic [LW-1:0]  lim, lim_ext;

  assign in_req.ready = (state_r == ST_IDLE);
  assign accept       = in_req.valid & in_req.ready;
  // finish the update only when the result slot is free or being drained
  assign commit       = (state_r == ST_EXEC) && (!out_valid_r || out_rsp.ready);

  // an insert at the front makes every cell shift, the first one loading the value
  assign front_ins = (req_r == REQ_INS_FRONT);

  assign ctl.load  = accept;
  assign ctl.key   = in_req.key;
  assign ctl.op    = commit ? op : OP_HOLD;
  assign ctl.value = value_r;

  // cell chain
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_W-1:0] l_data, r_data;
    logic             l_occ, l_seen, l_first, r_occ;
    if (i == 0) begin : g_front
      assign l_data  = value_r;
      assign l_occ   = 1'b1;
      assign l_seen  = front_ins;
      assign l_first = front_ins;
    end else begin : g_mid
      assign l_data  = data_w[i-1];
      assign l_occ   = occ_w[i-1];
      assign l_seen  = seen_w[i-1];
      assign l_first = first_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_back
      assign r_data = data_w[i];
      assign r_occ  = 1'b0;
    end else begin : g_inner
      assign r_data = data_w[i+1];
      assign r_occ  = occ_w[i+1];
    end
    bobl_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .left_data  (l_data),
      .left_occ   (l_occ),
      .left_seen  (l_seen),
      .left_first (l_first),
      .right_data (r_data),
      .right_occ  (r_occ),
      .data       (data_w[i]),
      .occ        (occ_w[i]),
      .seen_out   (seen_w[i]),
      .first_out  (first_w[i])
    );
  end

  // encode the position of the first matching cell
  always_comb begin
    pos = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      if (first_w[i]) begin
        pos = pos | IW'(i);
      end
    end
  end

  assign found = seen_w[CAPACITY-1];

  // effective limit: register value capped at the capacity
  assign lim_ext = LW'(limit_r);
  assign lim     = (lim_ext > LW'(CAPACITY)) ? LW'(CAPACITY) : lim_ext;
  assign full    = (LW'(count_r) >= lim);

  // decide status, count and cell operation for the held request
  always_comb begin
    logic has_pos;
    logic empty;
    has_pos     = 1'b0;
    empty       = (count_r == '0);
    op          = OP_HOLD;
    status_nxt  = ST_OK;
    count_nxt   = count_r;
    case (req_r)
      REQ_INS_FRONT: begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          op        = OP_INSERT;
          count_nxt = count_r + CW'(1);
        end
      end
      REQ_INS_AFTER: begin
        has_pos = 1'b1;
        if (full) begin
          status_nxt = ST_FULL;
        end else if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (!found) begin
          status_nxt = ST_NOT_FOUND;
        end else begin
          op        = OP_INSERT;
          count_nxt = count_r + CW'(1);
        end
      end
      REQ_DEL_AFTER: begin
        has_pos = 1'b1;
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (!found) begin
          status_nxt = ST_NOT_FOUND;
        end else if ((PW'(pos) + PW'(1)) >= PW'(count_r)) begin
          status_nxt = ST_NO_NEXT;
        end else begin
          op        = OP_DEL_AFTER;
          count_nxt = count_r - CW'(1);
        end
      end
      REQ_DEL_LAST: begin
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else begin
          op        = OP_DEL_LAST;
          count_nxt = count_r - CW'(1);
        end
      end
      REQ_SEARCH: begin
        has_pos = 1'b1;
        if (empty) begin
          status_nxt = ST_EMPTY;
        end else if (!found) begin
          status_nxt = ST_NOT_FOUND;
        end
      end
      default: begin
      end
    endcase
    pos_out_nxt = has_pos ? POS_W'(pos) : '0;
    cnt_out_nxt = CNT_OUT_W'(count_nxt);
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: if (commit) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
    if (commit) begin
      out_valid_nxt = 1'b1;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      limit_r     <= LIMIT_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (commit) begin
        count_r <= count_nxt;
      end
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
    end
  end

  // payload: hold the request, load the result on commit
  always_ff @(posedge clk) begin
    if (accept) begin
      req_r   <= in_req.req_type;
      value_r <= in_req.value;
    end
    if (commit) begin
      status_r  <= status_nxt;
      pos_out_r <= pos_out_nxt;
      cnt_out_r <= cnt_out_nxt;
    end
  end

  assign out_rsp.valid       = out_valid_r;
  assign out_rsp.status      = status_r;
  assign out_rsp.match_pos   = pos_out_r;
  assign out_rsp.entry_count = cnt_out_r;

endmodule

FILE: hdl/bobl_checker.sv
// Checker: port-level properties of the list block, bound to the top level.
module bobl_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [2:0] status,
  input logic [3:0] match_pos,
  input logic [4:0] entry_count
);
  import bobl_pkg::*;

  // a held result stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(status) && $stable(match_pos)
                                   && $stable(entry_count)))
    else $error("stalled result changed");

  // one request in flight at a time
  a_one_req: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("request taken while one is in flight");

  a_empty_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status == ST_EMPTY) |-> (entry_count == '0))
    else $error("empty status with nonzero count");

  a_nf_pos: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && status == ST_NOT_FOUND) |-> (match_pos == '0))
    else $error("not-found status with nonzero position");

endmodule

bind bounded_ordered_byte_list_top bobl_checker u_bobl_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_req.valid),
  .in_ready    (in_req.ready),
  .out_valid   (out_rsp.valid),
  .out_ready   (out_rsp.ready),
  .status      (out_rsp.status),
  .match_pos   (out_rsp.match_pos),
  .entry_count (out_rsp.entry_count)
);
